>>> design/tsam_pkg.sv
// shared types and constants of the threshold and slope anomaly monitor
package tsam_pkg;

  localparam int SAMPLE_DEPTH_DEF  = 64;
  localparam int ANOMALY_DEPTH_DEF = 64;
  localparam int CFG_IDX_W         = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL    = 3'd0,
    REG_VALUE_THRESHOLD = 3'd1,
    REG_THRESHOLD_HOLD  = 3'd2,
    REG_SLOPE_LIMIT     = 3'd3,
    REG_SAMPLE_WINDOW   = 3'd4,
    REG_SLOPE_HOLD      = 3'd5,
    REG_MODE_FLAGS      = 3'd6
  } cfg_reg_t;

  // bit positions in mode_flags
  localparam int MODE_TH_BELOW = 0;
  localparam int MODE_SL_BELOW = 1;
  localparam int MODE_SL_ABS   = 2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CHECK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_SMP_DEC,
    ST_SMP_RDO,
    ST_SMP_MUL,
    ST_SMP_CMP,
    ST_AGE_RD,
    ST_AGE_EV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        now_ms;
    logic signed [31:0] sample_value;
  } in_t;

  typedef struct packed {
    logic        stored;
    logic        threshold_hit;
    logic        slope_hit;
    logic        threshold_alarm;
    logic        slope_alarm;
    logic [31:0] last_threshold_time;
    logic [31:0] last_slope_time;
    logic        ring_overflow;
  } out_t;

  typedef struct packed {
    logic push;
    logic clear;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } ring_st_t;

endpackage

>>> design/tsam_stream_if.sv
// valid/ready stream channel with a typed payload
interface tsam_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/tsam_anom_ring.sv
// anomaly timestamp ring: memory with head and count, push, pop and clear
module tsam_anom_ring #(
  parameter int ANOMALY_DEPTH = tsam_pkg::ANOMALY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tsam_pkg::ring_ctl_t ctl,
  input  logic [31:0]         now_ms,
  output tsam_pkg::ring_st_t  st,
  output logic [31:0]         head_time
);
  localparam int AW = (ANOMALY_DEPTH > 1) ? $clog2(ANOMALY_DEPTH) : 1;
  localparam int CW = $clog2(ANOMALY_DEPTH + 1);

  logic [31:0]   mem [ANOMALY_DEPTH];
  logic [AW-1:0] head;
  logic [CW-1:0] cnt;
  logic [AW-1:0] head_inc;
  logic [CW:0]   sum;
  logic [AW-1:0] wa;

  always_comb begin
    head_inc    = (head == AW'(ANOMALY_DEPTH - 1)) ? '0 : head + AW'(1);
    sum         = (CW+1)'(head) + (CW+1)'(cnt);
    st.full     = (cnt == CW'(ANOMALY_DEPTH));
    st.nonempty = (cnt != '0);
    if (st.full) begin
      wa = head;
    end else if (sum >= (CW+1)'(ANOMALY_DEPTH)) begin
      wa = AW'(sum - (CW+1)'(ANOMALY_DEPTH));
    end else begin
      wa = AW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else if (ctl.clear) begin
      cnt <= '0;
    end else if (ctl.pop) begin
      head <= head_inc;
      cnt  <= cnt - CW'(1);
    end else if (ctl.push) begin
      if (st.full) begin
        head <= head_inc;
      end else begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear && !ctl.pop) begin
      mem[wa] <= now_ms;
    end
    head_time <= mem[head];
  end

endmodule

>>> design/tsam_slope.sv
// slope test by cross multiplication, product registered before the compare
module tsam_slope (
  input  logic               clk,
  input  logic               en,
  input  logic               abs_mode,
  input  logic signed [32:0] dv,
  input  logic signed [31:0] limit,
  input  logic [31:0]        dt,
  output logic               gt
);
  logic signed [33:0] lhs;
  logic signed [33:0] lim;
  logic signed [33:0] dv_x;
  logic signed [33:0] lim_x;
  logic signed [67:0] lhs_r;
  logic signed [67:0] prod_r;

  always_comb begin
    dv_x  = {dv[32], dv};
    lim_x = {{2{limit[31]}}, limit};
    lhs   = (abs_mode && dv_x < 0) ? -dv_x : dv_x;
    lim   = (abs_mode && lim_x < 0) ? -lim_x : lim_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_r  <= {{18{lhs[33]}}, lhs, 16'b0};
      prod_r <= lim * $signed({2'b00, dt});
    end
  end

  assign gt = (lhs_r > prod_r);

endmodule

>>> design/threshold_slope_anomaly_monitor.sv
// A check item passes ST_CHK_RD, ST_CHK_EV and ST_DONE; a rejected sample ST_SMP_DEC and
// ST_DONE; a stored sample ST_SMP_DEC, ST_SMP_RDO, ST_SMP_MUL, ST_SMP_CMP, ageing rounds of
// ST_AGE_RD and ST_AGE_EV, then ST_DONE, with a further round after every round that drops an
// entry from the sample ring or an anomaly ring (rings age together, at most one entry each per
// round). Ring memory reads are registered, and the slope product is registered before the
// compare. A finished result waits in the output register while the next item is accepted.
module threshold_slope_anomaly_monitor #(
  parameter int SAMPLE_DEPTH  = tsam_pkg::SAMPLE_DEPTH_DEF,
  parameter int ANOMALY_DEPTH = tsam_pkg::ANOMALY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tsam_stream_if.sink                    smp,
  tsam_stream_if.source                  res,
  input  logic                           cfg_we,
  input  logic [tsam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  localparam int SAW = $clog2(SAMPLE_DEPTH);
  localparam int SCW = $clog2(SAMPLE_DEPTH + 1);

  tsam_pkg::state_t state, state_next;

  logic [31:0]        min_interval, thold, window, shold;
  logic signed [31:0] thr, slim;
  logic [2:0]         mode;

  logic               kind;
  logic [31:0]        now;
  logic signed [31:0] val;

  logic [63:0]        smem [SAMPLE_DEPTH];
  logic [63:0]        srd;
  logic [SAW-1:0]     shead, snew;
  logic [SCW-1:0]     scnt;
  logic [31:0]        ntime;
  logic signed [31:0] nval;

  logic r_stored, r_th, r_sl, r_ta, r_sa, r_ovf;
  logic [31:0] last_t, last_s;
  logic slope_ok;

  tsam_pkg::ring_ctl_t tctl, pctl;
  tsam_pkg::ring_st_t  tst, pst;
  logic [31:0]         trd, prd;

  logic               accept, load;
  logic               reject, same_t, s_we, s_pop;
  logic [SAW-1:0]     s_wa, shead_inc;
  logic [SCW:0]       s_sum;
  logic [31:0]        dt;
  logic signed [32:0] dv;
  logic               gt, sl_anom, th_anom, t_pop, p_pop, mul_en;

  assign accept = smp.valid && smp.ready;
  assign smp.ready = !rst && (state == tsam_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= 32'd1;
      thr          <= '0;
      thold        <= '0;
      slim         <= '0;
      window       <= '0;
      shold        <= '0;
      mode         <= '0;
    end else if (cfg_we) begin
      case (tsam_pkg::cfg_reg_t'(cfg_index))
        tsam_pkg::REG_MIN_INTERVAL:    min_interval <= cfg_data;
        tsam_pkg::REG_VALUE_THRESHOLD: thr <= cfg_data;
        tsam_pkg::REG_THRESHOLD_HOLD:  thold <= cfg_data;
        tsam_pkg::REG_SLOPE_LIMIT:     slim <= cfg_data;
        tsam_pkg::REG_SAMPLE_WINDOW:   window <= cfg_data;
        tsam_pkg::REG_SLOPE_HOLD:      shold <= cfg_data;
        tsam_pkg::REG_MODE_FLAGS:      mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shead_inc = (shead == SAW'(SAMPLE_DEPTH - 1)) ? '0 : shead + SAW'(1);
    s_sum     = (SCW+1)'(shead) + (SCW+1)'(scnt);
    if (scnt == SCW'(SAMPLE_DEPTH)) begin
      s_wa = shead;
    end else if (s_sum >= (SCW+1)'(SAMPLE_DEPTH)) begin
      s_wa = SAW'(s_sum - (SCW+1)'(SAMPLE_DEPTH));
    end else begin
      s_wa = SAW'(s_sum);
    end
    reject  = (scnt != '0) && ((now - ntime) < min_interval);
    same_t  = (scnt != '0) && (ntime == now);
    dt      = ntime - srd[31:0];
    dv      = {nval[31], nval} - {srd[63], srd[63:32]};
    sl_anom = slope_ok && (mode[tsam_pkg::MODE_SL_BELOW] ? !gt : gt);
    th_anom = mode[tsam_pkg::MODE_TH_BELOW] ? (val < thr) : (val > thr);
    s_pop   = (scnt != '0) && ((now - srd[31:0]) > window);
    t_pop   = tst.nonempty && ((now - trd) > thold);
    p_pop   = pst.nonempty && ((now - prd) > shold);
  end

  always_comb begin
    state_next = state;
    tctl       = '0;
    pctl       = '0;
    s_we       = 1'b0;
    mul_en     = 1'b0;
    load       = 1'b0;
    case (state)
      tsam_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (smp.data.kind == tsam_pkg::KIND_CHECK) ? tsam_pkg::ST_CHK_RD
                                                             : tsam_pkg::ST_SMP_DEC;
        end
      end
      tsam_pkg::ST_CHK_RD: state_next = tsam_pkg::ST_CHK_EV;
      tsam_pkg::ST_CHK_EV: begin
        tctl.clear = tst.nonempty && ((now - trd) >= thold);
        pctl.clear = pst.nonempty && ((now - prd) >= shold);
        state_next = tsam_pkg::ST_DONE;
      end
      tsam_pkg::ST_SMP_DEC: begin
        s_we       = !reject;
        state_next = reject ? tsam_pkg::ST_DONE : tsam_pkg::ST_SMP_RDO;
      end
      tsam_pkg::ST_SMP_RDO: state_next = tsam_pkg::ST_SMP_MUL;
      tsam_pkg::ST_SMP_MUL: begin
        mul_en     = 1'b1;
        state_next = tsam_pkg::ST_SMP_CMP;
      end
      tsam_pkg::ST_SMP_CMP: begin
        pctl.push  = sl_anom;
        pctl.clear = !sl_anom;
        tctl.push  = th_anom;
        tctl.clear = !th_anom;
        state_next = tsam_pkg::ST_AGE_RD;
      end
      tsam_pkg::ST_AGE_RD: state_next = tsam_pkg::ST_AGE_EV;
      tsam_pkg::ST_AGE_EV: begin
        tctl.pop   = t_pop;
        pctl.pop   = p_pop;
        state_next = (s_pop || t_pop || p_pop) ? tsam_pkg::ST_AGE_RD : tsam_pkg::ST_DONE;
      end
      tsam_pkg::ST_DONE: begin
        load = !res.valid || res.ready;
        if (load) begin
          state_next = tsam_pkg::ST_IDLE;
        end
      end
      default: state_next = tsam_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsam_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample ring memory, head entry read every cycle
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[same_t ? snew : s_wa] <= {val, now};
    end
    srd <= smem[shead];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shead    <= '0;
      scnt     <= '0;
      last_t   <= '0;
      last_s   <= '0;
      r_stored <= 1'b0;
      r_th     <= 1'b0;
      r_sl     <= 1'b0;
      r_ta     <= 1'b0;
      r_sa     <= 1'b0;
      r_ovf    <= 1'b0;
    end else begin
      if (accept) begin
        r_stored <= 1'b0;
        r_th     <= 1'b0;
        r_sl     <= 1'b0;
        r_ta     <= 1'b0;
        r_sa     <= 1'b0;
        r_ovf    <= 1'b0;
      end
      if (state == tsam_pkg::ST_CHK_EV) begin
        r_ta <= tctl.clear;
        r_sa <= pctl.clear;
      end
      if (s_we) begin
        r_stored <= 1'b1;
        if (!same_t) begin
          if (scnt == SCW'(SAMPLE_DEPTH)) begin
            shead <= shead_inc;
            r_ovf <= 1'b1;
          end else begin
            scnt <= scnt + SCW'(1);
          end
        end
      end
      if (state == tsam_pkg::ST_SMP_CMP) begin
        r_sl <= sl_anom;
        r_th <= th_anom;
        if ((sl_anom && pst.full) || (th_anom && tst.full)) begin
          r_ovf <= 1'b1;
        end
        if (sl_anom) begin
          last_s <= now;
        end
        if (th_anom) begin
          last_t <= now;
        end
      end
      if (state == tsam_pkg::ST_AGE_EV && s_pop) begin
        shead <= shead_inc;
        scnt  <= scnt - SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= smp.data.kind;
      now  <= smp.data.now_ms;
      val  <= smp.data.sample_value;
    end
    if (s_we) begin
      nval <= val;
      ntime <= now;
      if (!same_t) begin
        snew <= s_wa;
      end
    end
    if (mul_en) begin
      slope_ok <= (scnt >= SCW'(2)) && (dt != '0);
    end
  end

  tsam_slope u_slope (
    .clk      (clk),
    .en       (mul_en),
    .abs_mode (mode[tsam_pkg::MODE_SL_ABS]),
    .dv       (dv),
    .limit    (slim),
    .dt       (dt),
    .gt       (gt)
  );

  tsam_anom_ring #(.ANOMALY_DEPTH(ANOMALY_DEPTH)) u_thr_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tctl),
    .now_ms    (now),
    .st        (tst),
    .head_time (trd)
  );

  tsam_anom_ring #(.ANOMALY_DEPTH(ANOMALY_DEPTH)) u_slp_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pctl),
    .now_ms    (now),
    .st        (pst),
    .head_time (prd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.data.stored              <= r_stored;
      res.data.threshold_hit       <= r_th;
      res.data.slope_hit           <= r_sl;
      res.data.threshold_alarm     <= r_ta;
      res.data.slope_alarm         <= r_sa;
      res.data.last_threshold_time <= last_t;
      res.data.last_slope_time     <= last_s;
      res.data.ring_overflow       <= r_ovf;
    end
  end

  a_scnt_bound: assert property (@(posedge clk) disable iff (rst)
    scnt <= SCW'(SAMPLE_DEPTH))
    else $error("sample count above depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !smp.ready)
    else $error("second item taken while one is at work");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    load && !r_stored |-> !r_th && !r_sl && !r_ovf)
    else $error("hit or overflow on an unstored item");

  a_check_alarm: assert property (@(posedge clk) disable iff (rst)
    (state == tsam_pkg::ST_SMP_DEC) |=> !r_ta && !r_sa)
    else $error("alarm raised by a sample item");

  a_kind_path: assert property (@(posedge clk) disable iff (rst)
    (state == tsam_pkg::ST_CHK_EV) |-> kind == tsam_pkg::KIND_CHECK)
    else $error("check path entered by a sample");

endmodule
